@@ src/mns_pkg.sv @@
package mns_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CH_TBL,
        S_CH_EVAL,
        S_CH_NEXT,
        S_STOP,
        S_FIN
    } t_state;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TICK = 2'd1;
    localparam logic [1:0] ACT_STOP = 2'd2;

    localparam logic [1:0] KIND_KEY_ON  = 2'd0;
    localparam logic [1:0] KIND_KEY_OFF = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam logic       REG_NUM_CHANNELS   = 1'b0;
    localparam logic [3:0] NUM_CHANNELS_RESET = 4'd12;

    typedef struct packed {
        logic        lend;
        logic        lstart;
        logic [15:0] dur;
        logic [15:0] note;
        logic [3:0]  chn;
        logic [7:0]  smp;
    } t_event;

    typedef struct packed {
        logic [15:0] tick;
        logic [7:0]  pos;
        logic [7:0]  off;
        logic        started;
        logic [7:0]  loop;
    } t_chan;

endpackage

@@ src/mns_event_table.sv @@
module mns_event_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_waddr,
    input  mns_pkg::t_event                i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_raddr,
    output mns_pkg::t_event                o_rdata
);

    mns_pkg::t_event r_mem [TABLE_DEPTH];
    mns_pkg::t_event r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mns_chan_mem.sv @@
module mns_chan_mem #(
    parameter int MAX_CHANNELS = 12,
    localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_we,
    input  logic [CH_AW-1:0]  i_waddr,
    input  mns_pkg::t_chan    i_wdata,
    input  logic              i_re,
    input  logic [CH_AW-1:0]  i_raddr,
    output mns_pkg::t_chan    o_rdata
);

    mns_pkg::t_chan          r_mem [MAX_CHANNELS];
    mns_pkg::t_chan          r_rdata;
    logic [MAX_CHANNELS-1:0] r_valid;
    logic                    r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // An entry that was never written since reset or the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

@@ src/mns_apb_regs.sv @@
module mns_apb_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [3:0]  o_num_channels
);

    logic [3:0] r_num_channels;
    logic       sel_num;

    assign sel_num = (paddr[2] == mns_pkg::REG_NUM_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= mns_pkg::NUM_CHANNELS_RESET;
        end else if (psel && penable && pwrite && sel_num) begin
            r_num_channels <= pwdata[3:0];
        end
    end

    assign prdata         = sel_num ? {28'd0, r_num_channels} : 32'd0;
    assign pready         = 1'b1;
    assign o_num_channels = r_num_channels;

endmodule

@@ src/multichannel_note_sequencer.sv @@
// Multichannel note sequencer.
// Requests arrive on the slave stream: tuser carries the action (load a record,
// tick, stop), tdata the record fields. Results leave on the master stream with
// the result kind in tuser and tlast on the final result of a tick or a stop.
// A load gives no result. For each active channel a tick passes through a table
// read state and an evaluate state, plus a next-record state when a finished
// event must check the following record; each channel needs one read of the
// channel state memory and one or two reads of the event table. The sequencer
// handles one request at a time and takes the next request while its last
// result still waits in the output register. When the receiver stalls, the
// sequencer holds at the next result until the output register frees up. Reset
// clears all channel state through valid bits, clears the load count and the
// stop cursor, and sets num_channels to 12. The num_channels register is at
// byte address 0 of the APB port.
module multichannel_note_sequencer #(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CHANNELS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: sample_id[7:0], channel[11:8], note_key[27:12], duration[43:28],
    //        loop_start[44], loop_end[45], zero fill[47:46]
    input  logic [47:0] i_s_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: voice[3:0], sample_out[11:4], note_out[27:12], zero fill[31:28]
    output logic [31:0] o_m_tdata,
    // tuser: kind[1:0]
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TA_W  = $clog2(TABLE_DEPTH);
    localparam int LI_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (LI_W > 9) ? LI_W : 9;

    mns_pkg::t_state r_state, n_state;

    logic [LI_W-1:0] r_load_index;
    logic [7:0]      r_run;
    logic [3:0]      r_cursor;
    logic [3:0]      r_chan;
    logic            r_stop;
    logic            r_rec_ok;
    logic [3:0]      r_ld_chn;
    logic            r_ld_lstart;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [3:0]  r_out_voice;
    logic [7:0]  r_out_smp;
    logic [15:0] r_out_note;
    logic        r_out_last;

    logic [3:0]      num_channels;
    logic [4:0]      n_act;
    mns_pkg::t_event s_rec;
    logic [1:0]      s_act;
    logic            acc_in;
    logic            out_free;
    logic            full;

    mns_pkg::t_chan  chan_q;
    mns_pkg::t_event rec_raw;
    mns_pkg::t_event rec;

    logic [CMP_W-1:0] li_ext;
    logic [CMP_W-1:0] idx_cur;
    logic [CMP_W-1:0] idx_nxt;
    logic [7:0]       pos_inc;
    logic             eval_run;
    logic             eval_emit;
    logic             eval_go;
    logic             ch_last;
    logic             stop_last;
    logic             ld_in_max;
    logic             ld_start;
    logic [7:0]       ld_run;

    logic             tbl_we;
    logic [TA_W-1:0]  tbl_waddr;
    logic             tbl_re;
    logic [TA_W-1:0]  tbl_raddr;
    logic             rec_ok_set;
    logic             chan_we;
    logic [CH_AW-1:0] chan_waddr;
    mns_pkg::t_chan   chan_wdata;
    logic             chan_re;
    logic [CH_AW-1:0] chan_raddr;
    logic             chan_clr;
    logic             chan_adv;
    logic             emit;
    logic [1:0]       e_kind;
    logic [3:0]       e_voice;
    logic [7:0]       e_smp;
    logic [15:0]      e_note;
    logic             e_last;

    mns_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_num_channels (num_channels)
    );

    mns_event_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (s_rec),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (rec_raw)
    );

    mns_chan_mem #(.MAX_CHANNELS(MAX_CHANNELS)) u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (chan_clr),
        .i_we    (chan_we),
        .i_waddr (chan_waddr),
        .i_wdata (chan_wdata),
        .i_re    (chan_re),
        .i_raddr (chan_raddr),
        .o_rdata (chan_q)
    );

    assign s_act         = i_s_tuser;
    assign s_rec.smp     = i_s_tdata[7:0];
    assign s_rec.chn     = i_s_tdata[11:8];
    assign s_rec.note    = i_s_tdata[27:12];
    assign s_rec.dur     = i_s_tdata[43:28];
    assign s_rec.lstart  = i_s_tdata[44];
    assign s_rec.lend    = i_s_tdata[45];

    assign n_act    = ({1'b0, num_channels} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS)
                                                                : {1'b0, num_channels};
    assign acc_in   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign full     = (r_load_index == LI_W'(TABLE_DEPTH));

    assign rec      = r_rec_ok ? rec_raw : '0;
    assign li_ext   = CMP_W'(r_load_index);
    assign pos_inc  = chan_q.pos + 8'd1;
    assign idx_cur  = CMP_W'(chan_q.off) + CMP_W'(chan_q.pos);
    assign idx_nxt  = CMP_W'(chan_q.off) + CMP_W'(pos_inc);

    assign eval_run  = (chan_q.tick < rec.dur);
    assign eval_emit = eval_run ? (chan_q.tick == 16'd0) : (r_chan == r_cursor);
    assign eval_go   = !eval_emit || out_free;
    assign ch_last   = (({1'b0, r_chan} + 5'd1) >= n_act);
    assign stop_last = ({1'b0, r_chan} == 5'(MAX_CHANNELS - 1));

    assign ld_in_max = ({1'b0, r_ld_chn} < 5'(MAX_CHANNELS));
    assign ld_start  = ({1'b0, r_ld_chn} < n_act) && !chan_q.started;
    assign ld_run    = ld_start ? 8'd0 : r_run;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mns_pkg::S_IDLE: begin
                if (acc_in) begin
                    unique case (s_act)
                        mns_pkg::ACT_LOAD: n_state = full ? mns_pkg::S_IDLE : mns_pkg::S_LOAD;
                        mns_pkg::ACT_TICK: n_state = (n_act == 5'd0) ? mns_pkg::S_FIN
                                                                    : mns_pkg::S_CH_TBL;
                        mns_pkg::ACT_STOP: n_state = mns_pkg::S_STOP;
                        default:           n_state = mns_pkg::S_IDLE;
                    endcase
                end
            end
            mns_pkg::S_LOAD:   n_state = mns_pkg::S_IDLE;
            mns_pkg::S_CH_TBL: n_state = mns_pkg::S_CH_EVAL;
            mns_pkg::S_CH_EVAL: begin
                if (eval_go) begin
                    if (eval_run || rec.lend) begin
                        n_state = ch_last ? mns_pkg::S_FIN : mns_pkg::S_CH_TBL;
                    end else begin
                        n_state = mns_pkg::S_CH_NEXT;
                    end
                end
            end
            mns_pkg::S_CH_NEXT: n_state = ch_last ? mns_pkg::S_FIN : mns_pkg::S_CH_TBL;
            mns_pkg::S_STOP: begin
                if (out_free && stop_last) begin
                    n_state = mns_pkg::S_FIN;
                end
            end
            mns_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = mns_pkg::S_IDLE;
                end
            end
            default: n_state = mns_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_state == mns_pkg::S_IDLE);
        tbl_we     = 1'b0;
        tbl_waddr  = r_load_index[TA_W-1:0];
        tbl_re     = 1'b0;
        tbl_raddr  = idx_cur[TA_W-1:0];
        rec_ok_set = 1'b0;
        chan_we    = 1'b0;
        chan_waddr = r_chan[CH_AW-1:0];
        chan_wdata = chan_q;
        chan_re    = 1'b0;
        chan_raddr = CH_AW'(r_chan + 4'd1);
        chan_clr   = 1'b0;
        chan_adv   = 1'b0;
        emit       = 1'b0;
        e_kind     = mns_pkg::KIND_DONE;
        e_voice    = 4'd0;
        e_smp      = 8'd0;
        e_note     = 16'd0;
        e_last     = 1'b0;
        unique case (r_state)
            mns_pkg::S_IDLE: begin
                if (acc_in && s_act == mns_pkg::ACT_LOAD && !full) begin
                    tbl_we     = 1'b1;
                    chan_re    = 1'b1;
                    chan_raddr = s_rec.chn[CH_AW-1:0];
                end else if (acc_in && s_act == mns_pkg::ACT_TICK && n_act != 5'd0) begin
                    chan_re    = 1'b1;
                    chan_raddr = '0;
                end
            end
            mns_pkg::S_LOAD: begin
                chan_waddr = r_ld_chn[CH_AW-1:0];
                chan_we    = ld_in_max && (ld_start || r_ld_lstart);
                if (ld_start) begin
                    chan_wdata.off     = li_ext[7:0];
                    chan_wdata.started = 1'b1;
                end
                if (r_ld_lstart) begin
                    chan_wdata.loop = ld_run;
                end
            end
            mns_pkg::S_CH_TBL: begin
                tbl_re     = 1'b1;
                tbl_raddr  = idx_cur[TA_W-1:0];
                rec_ok_set = (idx_cur < li_ext);
            end
            mns_pkg::S_CH_EVAL: begin
                if (eval_go) begin
                    emit    = eval_emit;
                    e_voice = rec.chn;
                    if (eval_run) begin
                        e_kind          = mns_pkg::KIND_KEY_ON;
                        e_smp           = rec.smp;
                        e_note          = rec.note;
                        chan_we         = 1'b1;
                        chan_wdata.tick = chan_q.tick + 16'd1;
                    end else begin
                        e_kind = mns_pkg::KIND_KEY_OFF;
                        if (rec.lend) begin
                            chan_we         = 1'b1;
                            chan_wdata.tick = 16'd0;
                            chan_wdata.pos  = chan_q.loop;
                        end else begin
                            tbl_re     = 1'b1;
                            tbl_raddr  = idx_nxt[TA_W-1:0];
                            rec_ok_set = (idx_nxt < li_ext);
                        end
                    end
                    if (eval_run || rec.lend) begin
                        chan_adv = 1'b1;
                        chan_re  = !ch_last;
                    end
                end
            end
            mns_pkg::S_CH_NEXT: begin
                chan_we         = 1'b1;
                chan_wdata.tick = 16'd0;
                chan_wdata.pos  = (!r_rec_ok || rec.chn != r_chan) ? chan_q.loop : pos_inc;
                chan_adv        = 1'b1;
                chan_re         = !ch_last;
            end
            mns_pkg::S_STOP: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_kind   = mns_pkg::KIND_KEY_OFF;
                    e_voice  = r_chan;
                    chan_adv = 1'b1;
                end
            end
            mns_pkg::S_FIN: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_kind   = mns_pkg::KIND_DONE;
                    e_last   = 1'b1;
                    chan_clr = r_stop;
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mns_pkg::S_IDLE;
            r_load_index <= '0;
            r_run        <= 8'd0;
            r_cursor     <= 4'd0;
            r_chan       <= 4'd0;
            r_stop       <= 1'b0;
            r_rec_ok     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc_in) begin
                r_chan <= 4'd0;
                r_stop <= (s_act == mns_pkg::ACT_STOP);
            end else if (chan_adv) begin
                r_chan <= r_chan + 4'd1;
            end
            if (tbl_re) begin
                r_rec_ok <= rec_ok_set;
            end
            if (r_state == mns_pkg::S_LOAD) begin
                r_load_index <= r_load_index + LI_W'(1);
                r_run        <= ld_run + 8'd1;
            end
            if (r_state == mns_pkg::S_FIN && out_free) begin
                if (r_stop) begin
                    r_load_index <= '0;
                    r_run        <= 8'd0;
                    r_cursor     <= 4'd0;
                end else if (n_act != 5'd0 && ({1'b0, r_cursor} + 5'd1) < n_act) begin
                    r_cursor <= r_cursor + 4'd1;
                end else begin
                    r_cursor <= 4'd0;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_ld_chn    <= s_rec.chn;
            r_ld_lstart <= s_rec.lstart;
        end
        if (emit) begin
            r_out_kind  <= e_kind;
            r_out_voice <= e_voice;
            r_out_smp   <= e_smp;
            r_out_note  <= e_note;
            r_out_last  <= e_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_note, r_out_smp, r_out_voice};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule
